// ===== rtl/pcmux_pkg.sv =====
// Package for the priority command multiplexer: field widths, register map,
// opcode codes and the owner and flag structs shared by the core and top level.
// No dependencies.
package pcmux_pkg;

	localparam int REG_SOURCES = 4;
	localparam int SRC_W       = 2;
	localparam int PRIO_W      = 32;
	localparam int TMO_W       = 16;
	localparam int WORD_W      = 32;
	localparam int WORDS       = 6;
	localparam int CFG_IDX_W   = 3;

	// Register map: priorities first, then timeouts.
	localparam int REG_PRIO_BASE = 0;
	localparam int REG_TMO_BASE  = REG_PRIO_BASE + REG_SOURCES;

	localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(100);

	localparam logic OP_CMD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef logic [PRIO_W-1:0] prio_t;
	typedef logic [TMO_W-1:0]  tmo_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic             active;
		logic [SRC_W-1:0] idx;
	} owner_t;

	typedef struct packed {
		logic forward;
		logic changed;
	} mux_flags_t;

endpackage

// ===== rtl/priority_command_mux_with_timeout_unit.sv =====
// Top level of the priority command multiplexer with per-source timeout.
// Depends on pcmux_pkg and pcmux_core.
//
// Takes one beat per clock while in_stall is low: a velocity command from
// one of the sources or a time tick, and returns exactly one result beat per
// input beat. An accepted beat is held in the input register and then moves
// to the result register, from which its result is offered. The owner and
// the silence counters are updated in the same cycle that the item leaves
// the input register, so consecutive beats run at one per cycle without
// bubbles; only a stall on the result side holds the pipe. Priorities and
// timeouts are written through the configuration port, which is always ready.
module priority_command_mux_with_timeout_unit import pcmux_pkg::*; #(
	parameter int SOURCES    = 4,
	parameter int TIMER_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [SRC_W-1:0]      source,
	input  logic signed [31:0]    linear_x,
	input  logic signed [31:0]    linear_y,
	input  logic signed [31:0]    linear_z,
	input  logic signed [31:0]    angular_x,
	input  logic signed [31:0]    angular_y,
	input  logic signed [31:0]    angular_z,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  forward_valid,
	output logic signed [31:0]    out_linear_x,
	output logic signed [31:0]    out_linear_y,
	output logic signed [31:0]    out_linear_z,
	output logic signed [31:0]    out_angular_x,
	output logic signed [31:0]    out_angular_y,
	output logic signed [31:0]    out_angular_z,
	output logic                  owner_changed,
	output logic                  owner_active,
	output logic [SRC_W-1:0]      owner_source,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]           cfg_data
);

	prio_t  [REG_SOURCES-1:0]             prio_q;
	tmo_t   [REG_SOURCES-1:0]             tmo_q;
	owner_t                               own_q;
	owner_t                               own_d;
	logic [SOURCES-1:0][TIMER_BITS-1:0]   cnt_q;
	logic [SOURCES-1:0][TIMER_BITS-1:0]   cnt_d;
	mux_flags_t                           flags;

	logic                     v_s1;
	logic                     op_s1;
	logic [SRC_W-1:0]         src_s1;
	word_t [WORDS-1:0]        words_s1;

	logic                     v_s2;
	logic                     fwd_s2;
	logic                     chg_s2;
	owner_t                   own_s2;
	word_t [WORDS-1:0]        words_s2;

	logic                     out_free;
	logic                     s1_adv;
	logic                     in_take;

	assign cfg_ready = 1'b1;

	// The result register frees up when empty or when its beat is taken.
	assign out_free = !v_s2 || !out_stall;
	assign s1_adv   = v_s1 && out_free;
	assign in_stall = v_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_SOURCES; i++) begin
				prio_q[i] <= PRIO_W'(i);
				tmo_q[i]  <= TMO_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < REG_SOURCES; i++) begin
				if (cfg_index == CFG_IDX_W'(REG_PRIO_BASE + i)) begin
					prio_q[i] <= cfg_data;
				end
				if (cfg_index == CFG_IDX_W'(REG_TMO_BASE + i)) begin
					tmo_q[i] <= cfg_data[TMO_W-1:0];
				end
			end
		end
	end

	pcmux_core #(
		.SOURCES    (SOURCES),
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.op    (op_s1),
		.src   (src_s1),
		.own_q (own_q),
		.cnt_q (cnt_q),
		.prio  (prio_q),
		.tmo   (tmo_q),
		.own_d (own_d),
		.cnt_d (cnt_d),
		.flags (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			own_q <= '0;
			cnt_q <= '0;
		end else begin
			if (in_take) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				v_s2  <= 1'b1;
				own_q <= own_d;
				cnt_q <= cnt_d;
			end else if (!out_stall) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1       <= opcode;
			src_s1      <= source;
			words_s1[0] <= linear_x;
			words_s1[1] <= linear_y;
			words_s1[2] <= linear_z;
			words_s1[3] <= angular_x;
			words_s1[4] <= angular_y;
			words_s1[5] <= angular_z;
		end
		if (s1_adv) begin
			fwd_s2   <= flags.forward;
			chg_s2   <= flags.changed;
			own_s2   <= own_d;
			// Words read as zero unless the command was forwarded.
			words_s2 <= flags.forward ? words_s1 : '0;
		end
	end

	assign out_valid     = v_s2;
	assign forward_valid = fwd_s2;
	assign owner_changed = chg_s2;
	assign owner_active  = own_s2.active;
	assign owner_source  = own_s2.idx;
	assign out_linear_x  = words_s2[0];
	assign out_linear_y  = words_s2[1];
	assign out_linear_z  = words_s2[2];
	assign out_angular_x = words_s2[3];
	assign out_angular_y = words_s2[4];
	assign out_angular_z = words_s2[5];

endmodule

// ===== rtl/pcmux_core.sv =====
// Next-state logic of the multiplexer: grant decision and counter clear for a
// command beat, silence counter advance with owner expiry for a tick beat.
// Depends on pcmux_pkg.
module pcmux_core import pcmux_pkg::*; #(
	parameter int SOURCES    = 4,
	parameter int TIMER_BITS = 16
) (
	input  logic                                 op,
	input  logic [SRC_W-1:0]                     src,
	input  owner_t                               own_q,
	input  logic [SOURCES-1:0][TIMER_BITS-1:0]   cnt_q,
	input  prio_t [REG_SOURCES-1:0]              prio,
	input  tmo_t  [REG_SOURCES-1:0]              tmo,
	output owner_t                               own_d,
	output logic [SOURCES-1:0][TIMER_BITS-1:0]   cnt_d,
	output mux_flags_t                           flags
);

	localparam int CMP_W = (TIMER_BITS > TMO_W) ? TIMER_BITS : TMO_W;

	logic                src_ok;
	logic                grant;
	logic                take_over;
	logic [SOURCES-1:0]  expire;
	logic [SOURCES-1:0]  drop_vec;
	logic                drop;

	assign src_ok = (int'(src) < SOURCES);
	assign grant  = src_ok && (!own_q.active || (own_q.idx == src) ||
		(prio[src] > prio[own_q.idx]));
	assign take_over = grant && (!own_q.active || (own_q.idx != src));

	for (genvar g = 0; g < SOURCES; g++) begin : g_cnt
		logic [TIMER_BITS-1:0] nxt;
		logic [TMO_W-1:0]      limit;

		assign nxt = cnt_q[g] + TIMER_BITS'(1);
		// Sources without a timeout register see a limit of zero and expire every tick.
		if (g < REG_SOURCES) begin : g_reg
			assign limit = tmo[g];
			assign drop_vec[g] = expire[g] && own_q.active && (int'(own_q.idx) == g);
		end else begin : g_noreg
			assign limit = '0;
			assign drop_vec[g] = 1'b0;
		end
		assign expire[g] = (CMP_W'(nxt) >= CMP_W'(limit));

		always_comb begin
			if (op == OP_TICK) begin
				cnt_d[g] = expire[g] ? '0 : nxt;
			end else if (src_ok && (int'(src) == g)) begin
				cnt_d[g] = '0;
			end else begin
				cnt_d[g] = cnt_q[g];
			end
		end
	end

	assign drop = |drop_vec;

	always_comb begin
		own_d         = own_q;
		flags.forward = 1'b0;
		flags.changed = 1'b0;
		if (op == OP_TICK) begin
			if (drop) begin
				own_d         = '0;
				flags.changed = 1'b1;
			end
		end else begin
			flags.forward = grant;
			if (take_over) begin
				own_d.active  = 1'b1;
				own_d.idx     = src;
				flags.changed = 1'b1;
			end
		end
	end

endmodule
